// ===== src/mdfs_pkg.sv =====
// Shared types, codes and constants for the depth-first maze carver.
`timescale 1ns / 1ps
`default_nettype none

package mdfs_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int COORD_W  = 6;
    localparam int DIM_W    = 7;
    localparam int CELLS_W  = 14;
    localparam int PICK_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    typedef enum logic [1:0] {
        ACT_CARVE     = 2'd0,
        ACT_BACKTRACK = 2'd1,
        ACT_DONE      = 2'd2,
        ACT_START     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_EXEC
    } walk_state_t;

    // Clamped grid size and its cell total, settled from the config registers.
    typedef struct packed {
        logic [DIM_W-1:0]   rows;
        logic [DIM_W-1:0]   cols;
        logic [CELLS_W-1:0] cells;
    } grid_dims_t;

endpackage

`default_nettype wire

// ===== src/mdfs_ifs.sv =====
// Channel interfaces: command, result and configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface mdfs_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [mdfs_pkg::PICK_W-1:0] random_pick;

    modport source (output valid, mode, random_pick, input ready);
    modport sink   (input valid, mode, random_pick, output ready);
endinterface

interface mdfs_result_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic [mdfs_pkg::COORD_W-1:0] from_col;
    logic [mdfs_pkg::COORD_W-1:0] from_row;
    logic [mdfs_pkg::COORD_W-1:0] to_col;
    logic [mdfs_pkg::COORD_W-1:0] to_row;

    modport source (output valid, action, from_col, from_row, to_col, to_row, input ready);
    modport sink   (input valid, action, from_col, from_row, to_col, to_row, output ready);
endinterface

interface mdfs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mdfs_pkg::CFG_IDX_W-1:0] index;
    logic [mdfs_pkg::DIM_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/maze_dfs_backtracker.sv =====
// Top level of the randomized depth-first maze carver.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  cmd      | in  | valid / ready | mode, random_pick
//  result   | out | valid / ready | action, from_col, from_row, to_col, to_row
//  cfg      | in  | valid / ready | index (0 grid_rows, 1 grid_cols), data
//
//  A step command fetches three visited-map rows and the stack entry below the top at
//  accept, then picks, writes back and loads the result register in the exec state.
//  A start command first sweeps the visited map one row word per cycle through its
//  single write port before the origin is reported.
//  Reset clears the walk state and the config registers (8 by 8); map and stack
//  contents are not touched by reset, the first start sweeps the map.
//  A stalled result holds in its register; the walk waits in its last cycle until
//  the register frees, and a new command is taken only once the walk is idle.
`timescale 1ns / 1ps
`default_nettype none

module maze_dfs_backtracker #(
    parameter int MAX_ROWS = mdfs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mdfs_pkg::DEF_MAX_COLS
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    mdfs_cmd_if.sink      cmd,
    mdfs_result_if.source result,
    mdfs_cfg_if.sink      cfg
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int WORD  = 1 << CW;
    localparam int SAW   = $clog2(MAX_ROWS * MAX_COLS);
    localparam int EW    = RW + CW;

    logic [mdfs_pkg::DIM_W-1:0] rows_reg, cols_reg;
    mdfs_pkg::grid_dims_t       dims;

    logic            vm_rd_en, vm_wr_en;
    logic [RW-1:0]   vm_rd_row, vm_wr_row;
    logic [WORD-1:0] vm_wr_data, vm_mid, vm_dn, vm_up;

    logic           st_wr_en, st_rd_en;
    logic [SAW-1:0] st_wr_addr, st_rd_addr;
    logic [EW-1:0]  st_wr_data, st_rd_data;

    // Config writes always complete in one transfer
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= mdfs_pkg::DIM_RESET;
            cols_reg <= mdfs_pkg::DIM_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mdfs_pkg::CFG_GRID_ROWS: rows_reg <= cfg.data;
                mdfs_pkg::CFG_GRID_COLS: cols_reg <= cfg.data;
                default:                 ;
            endcase
        end
    end

    // Clamp the size registers: zero counts as one, anything above the build limit as
    // the limit. The cell total feeds the finished check at command accept.
    always_comb
    begin
        if (rows_reg == '0)
        begin
            dims.rows = 7'd1;
        end
        else if (9'(rows_reg) > 9'(MAX_ROWS))
        begin
            dims.rows = 7'(MAX_ROWS);
        end
        else
        begin
            dims.rows = rows_reg;
        end

        if (cols_reg == '0)
        begin
            dims.cols = 7'd1;
        end
        else if (9'(cols_reg) > 9'(MAX_COLS))
        begin
            dims.cols = 7'(MAX_COLS);
        end
        else
        begin
            dims.cols = cols_reg;
        end

        dims.cells = mdfs_pkg::CELLS_W'(dims.rows) * mdfs_pkg::CELLS_W'(dims.cols);
    end

    mdfs_walk #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .result     (result),
        .dims       (dims),
        .vm_rd_en   (vm_rd_en),
        .vm_rd_row  (vm_rd_row),
        .vm_wr_en   (vm_wr_en),
        .vm_wr_row  (vm_wr_row),
        .vm_wr_data (vm_wr_data),
        .vm_mid     (vm_mid),
        .vm_dn      (vm_dn),
        .vm_up      (vm_up),
        .st_wr_en   (st_wr_en),
        .st_wr_addr (st_wr_addr),
        .st_wr_data (st_wr_data),
        .st_rd_en   (st_rd_en),
        .st_rd_addr (st_rd_addr),
        .st_rd_data (st_rd_data)
    );

    // Visited map: row word per entry, current row and both vertical neighbours per read
    mdfs_vmap #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_vmap (
        .clk     (clk),
        .rd_en   (vm_rd_en),
        .rd_row  (vm_rd_row),
        .wr_en   (vm_wr_en),
        .wr_row  (vm_wr_row),
        .wr_data (vm_wr_data),
        .row_mid (vm_mid),
        .row_dn  (vm_dn),
        .row_up  (vm_up)
    );

    // Backtrack stack: the entry below the top is prefetched at accept for a pop
    mdfs_stack #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

endmodule

`default_nettype wire

// ===== src/mdfs_vmap.sv =====
// Visited map: one bit per cell, one row word per entry, split into even and odd row banks.
`timescale 1ns / 1ps
`default_nettype none

module mdfs_vmap #(
    parameter int MAX_ROWS = mdfs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mdfs_pkg::DEF_MAX_COLS
) (
    input  wire logic                               clk,
    input  wire logic                               rd_en,
    input  wire logic [$clog2(MAX_ROWS)-1:0]        rd_row,
    input  wire logic                               wr_en,
    input  wire logic [$clog2(MAX_ROWS)-1:0]        wr_row,
    input  wire logic [(1 << $clog2(MAX_COLS))-1:0] wr_data,
    output logic      [(1 << $clog2(MAX_COLS))-1:0] row_mid,
    output logic      [(1 << $clog2(MAX_COLS))-1:0] row_dn,
    output logic      [(1 << $clog2(MAX_COLS))-1:0] row_up
);

    localparam int RW     = $clog2(MAX_ROWS);
    localparam int WORD   = 1 << $clog2(MAX_COLS);
    localparam int BAW    = (RW > 1) ? RW - 1 : 1;
    localparam int BDEPTH = 1 << BAW;

    logic [WORD-1:0] bank0_mem [BDEPTH];
    logic [WORD-1:0] bank1_mem [BDEPTH];

    logic [WORD-1:0] b0a_reg, b0b_reg, b1a_reg, b1b_reg;
    logic            par_reg;

    logic [RW-1:0]  row_p1, row_m1;
    logic [BAW-1:0] a_mid, a_p1, a_m1, a_wr;
    logic [BAW-1:0] b0a_addr, b1a_addr;

    function automatic logic [BAW-1:0] half(input logic [RW-1:0] r);
        logic [RW-1:0] s;
        s = r >> 1;
        return s[BAW-1:0];
    endfunction

    // Row r sits in its own parity bank, rows r+1 and r-1 both sit in the other one.
    always_comb
    begin
        row_p1   = rd_row + 1'b1;
        row_m1   = rd_row - 1'b1;
        a_mid    = half(rd_row);
        a_p1     = half(row_p1);
        a_m1     = half(row_m1);
        a_wr     = half(wr_row);
        b0a_addr = rd_row[0] ? a_p1 : a_mid;
        b1a_addr = rd_row[0] ? a_mid : a_p1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_row[0])
        begin
            bank0_mem[a_wr] <= wr_data;
        end
        if (rd_en)
        begin
            b0a_reg <= bank0_mem[b0a_addr];
            b0b_reg <= bank0_mem[a_m1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_row[0])
        begin
            bank1_mem[a_wr] <= wr_data;
        end
        if (rd_en)
        begin
            b1a_reg <= bank1_mem[b1a_addr];
            b1b_reg <= bank1_mem[a_m1];
            par_reg <= rd_row[0];
        end
    end

    assign row_mid = par_reg ? b1a_reg : b0a_reg;
    assign row_dn  = par_reg ? b0a_reg : b1a_reg;
    assign row_up  = par_reg ? b0b_reg : b1b_reg;

endmodule

`default_nettype wire

// ===== src/mdfs_stack.sv =====
// Cell stack memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mdfs_stack #(
    parameter int MAX_ROWS = mdfs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mdfs_pkg::DEF_MAX_COLS
) (
    input  wire logic                                            clk,
    input  wire logic                                            wr_en,
    input  wire logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]            wr_addr,
    input  wire logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0]    wr_data,
    input  wire logic                                            rd_en,
    input  wire logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]            rd_addr,
    output logic      [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0]    rd_data
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int EW    = $clog2(MAX_ROWS) + $clog2(MAX_COLS);

    logic [EW-1:0] stack_mem [CELLS];
    logic [EW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/mdfs_walk.sv =====
// Walk sequencer: neighbour check, pick, carve or backtrack, map clearing and result register.
`timescale 1ns / 1ps
`default_nettype none

module mdfs_walk #(
    parameter int MAX_ROWS = mdfs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mdfs_pkg::DEF_MAX_COLS
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    mdfs_cmd_if.sink                                          cmd,
    mdfs_result_if.source                                     result,
    input  wire mdfs_pkg::grid_dims_t                         dims,
    output logic                                              vm_rd_en,
    output logic      [$clog2(MAX_ROWS)-1:0]                  vm_rd_row,
    output logic                                              vm_wr_en,
    output logic      [$clog2(MAX_ROWS)-1:0]                  vm_wr_row,
    output logic      [(1 << $clog2(MAX_COLS))-1:0]           vm_wr_data,
    input  wire logic [(1 << $clog2(MAX_COLS))-1:0]           vm_mid,
    input  wire logic [(1 << $clog2(MAX_COLS))-1:0]           vm_dn,
    input  wire logic [(1 << $clog2(MAX_COLS))-1:0]           vm_up,
    output logic                                              st_wr_en,
    output logic      [$clog2(MAX_ROWS*MAX_COLS)-1:0]         st_wr_addr,
    output logic      [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] st_wr_data,
    output logic                                              st_rd_en,
    output logic      [$clog2(MAX_ROWS*MAX_COLS)-1:0]         st_rd_addr,
    input  wire logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] st_rd_data
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int WORD  = 1 << CW;
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int SAW   = $clog2(CELLS);
    localparam int DW    = $clog2(CELLS + 1);
    localparam int CMPW  = (DW > mdfs_pkg::CELLS_W) ? DW : mdfs_pkg::CELLS_W;
    localparam int EW    = RW + CW;

    mdfs_pkg::walk_state_t state_reg, state_next;

    logic                        mode_reg;
    logic [mdfs_pkg::PICK_W-1:0] pick_reg;
    logic                        halt_reg;
    logic [RW-1:0]               cur_row_reg;
    logic [CW-1:0]               cur_col_reg;
    logic [DW-1:0]               depth_reg;
    logic [DW-1:0]               count_reg;
    logic [RW-1:0]               clr_row_reg;

    logic                           out_valid_reg;
    mdfs_pkg::action_t              out_action_reg;
    logic [mdfs_pkg::COORD_W-1:0]   out_fc_reg, out_fr_reg, out_tc_reg, out_tr_reg;

    logic acc, out_free, commit, clr_last;
    logic is_carve, is_back;

    // neighbour evaluation
    logic [8:0]    c_ext, r_ext, cols_ext, rows_ext;
    logic [CW-1:0] c_p1, c_m1;
    logic [RW-1:0] r_p1, r_m1;
    logic [3:0]    nb_ok;
    logic [2:0]    nb_cnt;
    logic [1:0]    nb_idx;
    logic [2:0]    seen;
    logic          found;
    mdfs_pkg::dir_t sel_dir;
    logic [RW-1:0]   new_row;
    logic [CW-1:0]   new_col;
    logic [WORD-1:0] sel_word;
    logic [WORD-1:0] carve_word;
    logic [DW-1:0]   depth_m2;
    logic [CMPW-1:0] count_cmp, cells_cmp;

    assign acc      = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign clr_last = (clr_row_reg == {RW{1'b1}});

    // Neighbour check against the live bounds and the three fetched map rows
    always_comb
    begin
        c_ext    = 9'(cur_col_reg);
        r_ext    = 9'(cur_row_reg);
        cols_ext = 9'(dims.cols);
        rows_ext = 9'(dims.rows);
        c_p1     = cur_col_reg + 1'b1;
        c_m1     = cur_col_reg - 1'b1;
        r_p1     = cur_row_reg + 1'b1;
        r_m1     = cur_row_reg - 1'b1;

        nb_ok[mdfs_pkg::DIR_RIGHT] = (c_ext + 9'd1 < cols_ext) && (r_ext < rows_ext)
                                     && !vm_mid[c_p1];
        nb_ok[mdfs_pkg::DIR_LEFT]  = (c_ext != 9'd0) && (c_ext - 9'd1 < cols_ext)
                                     && (r_ext < rows_ext) && !vm_mid[c_m1];
        nb_ok[mdfs_pkg::DIR_DOWN]  = (c_ext < cols_ext) && (r_ext + 9'd1 < rows_ext)
                                     && !vm_dn[cur_col_reg];
        nb_ok[mdfs_pkg::DIR_UP]    = (c_ext < cols_ext) && (r_ext != 9'd0)
                                     && (r_ext - 9'd1 < rows_ext) && !vm_up[cur_col_reg];

        nb_cnt = 3'($countones(nb_ok));
        case (nb_cnt)
            3'd1:    nb_idx = 2'd0;
            3'd2:    nb_idx = {1'b0, pick_reg[0]};
            3'd3:    nb_idx = (pick_reg == 2'd3) ? 2'd0 : pick_reg;
            default: nb_idx = pick_reg;
        endcase

        // rotating pick times through the valid list lands on entry pick mod count
        seen    = 3'd0;
        found   = 1'b0;
        sel_dir = mdfs_pkg::DIR_RIGHT;
        for (int d = 0; d < 4; d++)
        begin
            if (nb_ok[d])
            begin
                if (!found && seen == {1'b0, nb_idx})
                begin
                    sel_dir = mdfs_pkg::dir_t'(2'(d));
                    found   = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end

        case (sel_dir)
            mdfs_pkg::DIR_RIGHT:
            begin
                new_row  = cur_row_reg;
                new_col  = c_p1;
                sel_word = vm_mid;
            end
            mdfs_pkg::DIR_LEFT:
            begin
                new_row  = cur_row_reg;
                new_col  = c_m1;
                sel_word = vm_mid;
            end
            mdfs_pkg::DIR_DOWN:
            begin
                new_row  = r_p1;
                new_col  = cur_col_reg;
                sel_word = vm_dn;
            end
            default:
            begin
                new_row  = r_m1;
                new_col  = cur_col_reg;
                sel_word = vm_up;
            end
        endcase
        carve_word = sel_word | ({{(WORD-1){1'b0}}, 1'b1} << new_col);

        is_carve  = (mode_reg == mdfs_pkg::MODE_STEP) && !halt_reg && (nb_cnt != 3'd0);
        is_back   = (mode_reg == mdfs_pkg::MODE_STEP) && !halt_reg && (nb_cnt == 3'd0);
        depth_m2  = depth_reg - DW'(2);
        count_cmp = CMPW'(count_reg);
        cells_cmp = CMPW'(dims.cells);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mdfs_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    state_next = (cmd.mode == mdfs_pkg::MODE_START) ? mdfs_pkg::ST_CLEAR
                                                                    : mdfs_pkg::ST_EXEC;
                end
            end
            mdfs_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = mdfs_pkg::ST_EXEC;
                end
            end
            mdfs_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = mdfs_pkg::ST_IDLE;
                end
            end
            default: state_next = mdfs_pkg::ST_IDLE;
        endcase
    end

    // State outputs: memory ports and handshake
    always_comb
    begin
        cmd.ready  = 1'b0;
        commit     = 1'b0;
        vm_rd_en   = 1'b0;
        vm_rd_row  = cur_row_reg;
        vm_wr_en   = 1'b0;
        vm_wr_row  = clr_row_reg;
        vm_wr_data = (clr_row_reg == '0) ? {{(WORD-1){1'b0}}, 1'b1} : '0;
        st_rd_en   = 1'b0;
        st_rd_addr = (depth_reg > DW'(1)) ? depth_m2[SAW-1:0] : '0;
        st_wr_en   = 1'b0;
        st_wr_addr = '0;
        st_wr_data = '0;
        unique case (state_reg)
            mdfs_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                vm_rd_en  = cmd.valid;
                st_rd_en  = cmd.valid;
            end
            mdfs_pkg::ST_CLEAR:
            begin
                vm_wr_en = 1'b1;
            end
            mdfs_pkg::ST_EXEC:
            begin
                commit = out_free;
                if (mode_reg == mdfs_pkg::MODE_START)
                begin
                    st_wr_en = out_free;
                end
                else if (is_carve)
                begin
                    vm_wr_en   = out_free;
                    vm_wr_row  = new_row;
                    vm_wr_data = carve_word;
                    st_wr_en   = out_free && (depth_reg < DW'(CELLS));
                    st_wr_addr = depth_reg[SAW-1:0];
                    st_wr_data = {new_row, new_col};
                end
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mdfs_pkg::ST_IDLE;
            halt_reg      <= 1'b0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            depth_reg     <= '0;
            count_reg     <= '0;
            clr_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc)
            begin
                clr_row_reg <= '0;
                halt_reg    <= (count_cmp >= cells_cmp) || (depth_reg == '0);
            end
            else if (state_reg == mdfs_pkg::ST_CLEAR)
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
                if (mode_reg == mdfs_pkg::MODE_START)
                begin
                    cur_row_reg <= '0;
                    cur_col_reg <= '0;
                    depth_reg   <= DW'(1);
                    count_reg   <= DW'(1);
                end
                else if (is_carve)
                begin
                    cur_row_reg <= new_row;
                    cur_col_reg <= new_col;
                    count_reg   <= count_reg + 1'b1;
                    if (depth_reg < DW'(CELLS))
                    begin
                        depth_reg <= depth_reg + 1'b1;
                    end
                end
                else if (is_back)
                begin
                    cur_row_reg <= st_rd_data[EW-1:CW];
                    cur_col_reg <= st_rd_data[CW-1:0];
                    depth_reg   <= (depth_reg > DW'(1)) ? depth_reg - 1'b1 : '0;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command fields and result payload carry no reset
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            mode_reg <= cmd.mode;
            pick_reg <= cmd.random_pick;
        end
        if (commit)
        begin
            out_fc_reg <= mdfs_pkg::COORD_W'(cur_col_reg);
            out_fr_reg <= mdfs_pkg::COORD_W'(cur_row_reg);
            if (mode_reg == mdfs_pkg::MODE_START)
            begin
                out_action_reg <= mdfs_pkg::ACT_START;
                out_tc_reg     <= '0;
                out_tr_reg     <= '0;
            end
            else if (is_carve)
            begin
                out_action_reg <= mdfs_pkg::ACT_CARVE;
                out_tc_reg     <= mdfs_pkg::COORD_W'(new_col);
                out_tr_reg     <= mdfs_pkg::COORD_W'(new_row);
            end
            else if (is_back)
            begin
                out_action_reg <= mdfs_pkg::ACT_BACKTRACK;
                out_tc_reg     <= mdfs_pkg::COORD_W'(st_rd_data[CW-1:0]);
                out_tr_reg     <= mdfs_pkg::COORD_W'(st_rd_data[EW-1:CW]);
            end
            else
            begin
                out_action_reg <= mdfs_pkg::ACT_DONE;
                out_tc_reg     <= mdfs_pkg::COORD_W'(cur_col_reg);
                out_tr_reg     <= mdfs_pkg::COORD_W'(cur_row_reg);
            end
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.action   = out_action_reg;
    assign result.from_col = out_fc_reg;
    assign result.from_row = out_fr_reg;
    assign result.to_col   = out_tc_reg;
    assign result.to_row   = out_tr_reg;

    // Map reads and writes never share a cycle, so no forwarding is needed
    a_map_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        vm_rd_en |-> !vm_wr_en)
        else $error("visited map read and write in the same cycle");

    // Every stacked cell was marked visited, so the stack never outgrows the count
    a_depth_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= count_reg)
        else $error("stack depth exceeds visited count");

    a_carve_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && is_carve && mode_reg == mdfs_pkg::MODE_STEP)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("carve did not advance the visited count");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> state_reg != mdfs_pkg::ST_IDLE)
        else $error("accepted command left the sequencer idle");

    a_start_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && mode_reg == mdfs_pkg::MODE_START)
        |=> (cur_row_reg == '0 && cur_col_reg == '0 && depth_reg == DW'(1)))
        else $error("start did not reset the walk to the origin");

endmodule

`default_nettype wire

// ===== bench/maze_dfs_backtracker_checker.sv =====
// Channel monitor and walk predictor for the depth-first maze carver bench.
`timescale 1ns / 1ps

module maze_dfs_backtracker_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  logic                         cmd_ready,
    input  logic                         cmd_mode,
    input  logic [mdfs_pkg::PICK_W-1:0]  cmd_pick,
    input  logic                         res_valid,
    input  logic                         res_ready,
    input  logic [1:0]                   res_action,
    input  logic [mdfs_pkg::COORD_W-1:0] res_from_col,
    input  logic [mdfs_pkg::COORD_W-1:0] res_from_row,
    input  logic [mdfs_pkg::COORD_W-1:0] res_to_col,
    input  logic [mdfs_pkg::COORD_W-1:0] res_to_row,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [mdfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mdfs_pkg::DIM_W-1:0]   cfg_data,
    output int                           outstanding,
    output int                           mismatches
);
    import mdfs_pkg::*;

    localparam int CELL_TOTAL = DEF_MAX_ROWS * DEF_MAX_COLS;

    typedef struct packed {
        action_t            act;
        logic [COORD_W-1:0] from_col;
        logic [COORD_W-1:0] from_row;
        logic [COORD_W-1:0] to_col;
        logic [COORD_W-1:0] to_row;
    } walk_move_t;

    // Predicted walk state.
    bit                    seen_cell [CELL_TOTAL];
    logic [2*COORD_W-1:0]  trail [CELL_TOTAL];
    int                    trail_len;
    int                    seen_total;
    logic [COORD_W-1:0]    walk_col;
    logic [COORD_W-1:0]    walk_row;
    logic [DIM_W-1:0]      rows_reg;
    logic [DIM_W-1:0]      cols_reg;

    walk_move_t            pending_moves [$];
    int                    err_count = 0;

    function automatic int eff_dim(logic [DIM_W-1:0] v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void push_trail(int row, int col);
        if (trail_len < CELL_TOTAL)
        begin
            trail[trail_len] = {row[COORD_W-1:0], col[COORD_W-1:0]};
            trail_len++;
        end
    endfunction

    // One iteration of the randomized depth-first walk.
    function automatic void carve_step(input logic mode, input logic [PICK_W-1:0] pick,
                                       output walk_move_t mv);
        int      rows;
        int      cols;
        int      d;
        int      nc [4];
        int      nr [4];
        bit      open [4];
        bit      any_open;
        action_t act;
        rows = eff_dim(rows_reg, DEF_MAX_ROWS);
        cols = eff_dim(cols_reg, DEF_MAX_COLS);
        mv.from_col = walk_col;
        mv.from_row = walk_row;
        any_open = 1'b0;
        if (mode == MODE_START)
        begin
            foreach (seen_cell[i])
                seen_cell[i] = 1'b0;
            seen_cell[0] = 1'b1;
            seen_total = 1;
            trail_len = 0;
            push_trail(0, 0);
            walk_col = '0;
            walk_row = '0;
            act = ACT_START;
        end
        else if (seen_total >= rows * cols || trail_len == 0)
            act = ACT_DONE;
        else
        begin
            for (d = 0; d < 4; d++)
            begin
                nc[d] = walk_col;
                nr[d] = walk_row;
                case (dir_t'(d))
                    DIR_RIGHT: nc[d] = nc[d] + 1;
                    DIR_LEFT:  nc[d] = nc[d] - 1;
                    DIR_DOWN:  nr[d] = nr[d] + 1;
                    default:   nr[d] = nr[d] - 1;
                endcase
                open[d] = nc[d] >= 0 && nc[d] < cols && nr[d] >= 0 && nr[d] < rows &&
                          !seen_cell[nr[d] * DEF_MAX_COLS + nc[d]];
                any_open |= open[d];
            end
            if (any_open)
            begin
                d = 0;
                while (!open[d])
                    d++;
                for (int k = 0; k < pick; k++)
                begin
                    do
                        d = (d + 1) % 4;
                    while (!open[d]);
                end
                seen_cell[nr[d] * DEF_MAX_COLS + nc[d]] = 1'b1;
                seen_total++;
                push_trail(nr[d], nc[d]);
                walk_col = nc[d][COORD_W-1:0];
                walk_row = nr[d][COORD_W-1:0];
                act = ACT_CARVE;
            end
            else
            begin
                // Pop; the last entry empties the trail and becomes current.
                if (trail_len > 1)
                begin
                    trail_len--;
                    {walk_row, walk_col} = trail[trail_len - 1];
                end
                else
                begin
                    {walk_row, walk_col} = trail[0];
                    trail_len = 0;
                end
                act = ACT_BACKTRACK;
            end
        end
        mv.act    = act;
        mv.to_col = walk_col;
        mv.to_row = walk_row;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        walk_move_t want;
        walk_move_t got;
        if (!rst_n)
        begin
            foreach (seen_cell[i])
                seen_cell[i] = 1'b0;
            trail_len  = 0;
            seen_total = 0;
            walk_col   = '0;
            walk_row   = '0;
            rows_reg   = DIM_RESET;
            cols_reg   = DIM_RESET;
            pending_moves.delete();
            outstanding <= 0;
            mismatches  <= err_count;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                got = '{action_t'(res_action), res_from_col, res_from_row,
                        res_to_col, res_to_row};
                if (pending_moves.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                    err_count++;
                end
                else
                begin
                    want = pending_moves.pop_front();
                    check_field("action", want.act, got.act);
                    check_field("from_col", want.from_col, got.from_col);
                    check_field("from_row", want.from_row, got.from_row);
                    check_field("to_col", want.to_col, got.to_col);
                    check_field("to_row", want.to_row, got.to_row);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GRID_ROWS: rows_reg = cfg_data;
                    CFG_GRID_COLS: cols_reg = cfg_data;
                    default: ;
                endcase
            end
            if (cmd_valid && cmd_ready)
            begin
                carve_step(cmd_mode, cmd_pick, want);
                pending_moves = {pending_moves, want};
            end
            outstanding <= pending_moves.size();
            mismatches  <= err_count;
        end
    end

endmodule

// ===== bench/maze_dfs_backtracker_tb.sv =====
// Top of the maze carver bench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module maze_dfs_backtracker_tb;
    import mdfs_pkg::*;

    // Generous bound: at least 1600 items, starts that sweep the map, stalls.
    localparam int LIMIT_CYCLES = 400000;
    localparam int TARGET_ITEMS = 1600;
    // Receiver hold-off: when it starts and how long it lasts.
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    // Window of transfers with no idling on either side.
    localparam int QUIET_FROM   = 900;
    localparam int QUIET_TO     = 1150;

    logic clk = 1'b0;
    logic rst_n;

    mdfs_cmd_if    cmd_if ();
    mdfs_result_if res_if ();
    mdfs_cfg_if    cfg_if ();

    int outstanding;
    int mismatches;
    int items_sent  = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    maze_dfs_backtracker uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    maze_dfs_backtracker_checker walk_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_if.valid),
        .cmd_ready    (cmd_if.ready),
        .cmd_mode     (cmd_if.mode),
        .cmd_pick     (cmd_if.random_pick),
        .res_valid    (res_if.valid),
        .res_ready    (res_if.ready),
        .res_action   (res_if.action),
        .res_from_col (res_if.from_col),
        .res_from_row (res_if.from_row),
        .res_to_col   (res_if.to_col),
        .res_to_row   (res_if.to_row),
        .cfg_valid    (cfg_if.valid),
        .cfg_ready    (cfg_if.ready),
        .cfg_index    (cfg_if.index),
        .cfg_data     (cfg_if.data),
        .outstanding  (outstanding),
        .mismatches   (mismatches)
    );

    always #5 clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic bit quiet_window();
        return items_sent >= QUIET_FROM && items_sent < QUIET_TO;
    endfunction

    // Result side: random stalls, one long hold-off so the block backs up
    // into its command port while the sender keeps offering.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_if.ready <= 1'b0;
        end
        else if (!hold_done && items_sent >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= quiet_window() || $urandom_range(0, 99) >= 17;
    end

    // Offer one command and hold it until its transfer; sometimes idle first.
    task automatic send_cmd(input logic mode, input logic [PICK_W-1:0] pick);
        if (!quiet_window() && $urandom_range(0, 99) < 17)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.mode        <= mode;
        cmd_if.random_pick <= pick;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_step();
        send_cmd(MODE_STEP, PICK_W'($urandom_range(0, 3)));
    endtask

    // Drop valid and wait until every predicted result has come back,
    // then let the walk settle before touching the registers.
    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
        write_reg(CFG_GRID_ROWS, rows);
        write_reg(CFG_GRID_COLS, cols);
    endtask

    function automatic int eff_dim(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > DEF_MAX_ROWS) return DEF_MAX_ROWS;
        return v;
    endfunction

    // Mostly small sizes; now and then zero, the maximum or beyond it.
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return DIM_W'(DEF_MAX_ROWS);
            2:       return DIM_W'($urandom_range(DEF_MAX_ROWS + 1, 127));
            default: return DIM_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Large grid, a partial walk, then shrink the grid under the current cell
    // and keep stepping.
    task automatic shrink_phase();
        drain();
        set_grid($urandom_range(0, 1) ? DIM_W'(DEF_MAX_ROWS) : DIM_W'($urandom_range(65, 127)),
                 $urandom_range(0, 1) ? DIM_W'(DEF_MAX_COLS) : DIM_W'($urandom_range(65, 127)));
        send_cmd(MODE_START, PICK_W'($urandom_range(0, 3)));
        repeat ($urandom_range(40, 80)) send_step();
        drain();
        set_grid(DIM_W'($urandom_range(1, 3)), DIM_W'($urandom_range(1, 3)));
        repeat ($urandom_range(10, 30)) send_step();
    endtask

    // Mostly whole mazes walked to the end, with a few stray starts mixed in
    // and some phases that continue the previous walk on a new size.
    task automatic maze_phase();
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        int               cells;
        int               steps;
        rows = pick_dim();
        cols = pick_dim();
        if (eff_dim(rows) * eff_dim(cols) > 128)
            cols = DIM_W'($urandom_range(1, 2));
        cells = eff_dim(rows) * eff_dim(cols);
        drain();
        set_grid(rows, cols);
        if ($urandom_range(0, 6) != 0)
            send_cmd(MODE_START, PICK_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 4) == 0)
            steps = $urandom_range(1, 2 * cells);
        else
            steps = 2 * cells + $urandom_range(0, 3);
        repeat (steps)
        begin
            if ($urandom_range(0, 39) == 0)
                send_cmd(logic'($urandom_range(0, 1)), PICK_W'($urandom_range(0, 3)));
            else
                send_step();
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cmd_if.valid       <= 1'b0;
        cmd_if.mode        <= MODE_START;
        cmd_if.random_pick <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= CFG_GRID_ROWS;
        cfg_if.data        <= DIM_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Steps before any start: empty trail, nothing moves.
        send_cmd(MODE_STEP, 2'd0);
        send_cmd(MODE_STEP, 2'd3);

        // Single-cell grid: finished right after the start.
        drain();
        set_grid(7'd1, 7'd1);
        send_cmd(MODE_START, 2'd3);
        send_cmd(MODE_STEP, 2'd2);
        send_cmd(MODE_STEP, 2'd1);

        // Zero rows counts as one, oversized columns clamp to the maximum.
        drain();
        set_grid(7'd0, 7'd127);
        send_cmd(MODE_START, 2'd0);
        send_cmd(MODE_STEP, 2'd3);
        send_cmd(MODE_STEP, 2'd0);
        send_cmd(MODE_STEP, 2'd1);

        // 2x2: carves every cell, then reports finished.
        drain();
        set_grid(7'd2, 7'd2);
        send_cmd(MODE_START, 2'd1);
        send_cmd(MODE_STEP, 2'd3);
        send_cmd(MODE_STEP, 2'd2);
        send_cmd(MODE_STEP, 2'd1);
        send_cmd(MODE_STEP, 2'd0);
        send_cmd(MODE_STEP, 2'd0);
        send_cmd(MODE_STEP, 2'd0);
        send_cmd(MODE_STEP, 2'd3);

        // Pause the sender until the block is empty, then go random.
        drain();
        shrink_phase();
        while (items_sent < TARGET_ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
                shrink_phase();
            else
                maze_phase();
        end

        // Wait out the tail, then give any late result time to show up.
        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
